@@ hdl/pfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the prime filter and sum unit.
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int          DATA_W        = 32;
    localparam int          SUM_W         = 31;
    localparam logic [30:0] SUM_MAX       = 31'h7FFF_FFFF;
    localparam int          FIRST_DIVISOR = 2;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } pfs_rem_stat_t;

endpackage

@@ hdl/pfs_rem_unit.sv @@
// ----------------------------------------------------------------------------
// pfs_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle, then a
// one-cycle done pulse with a zero-remainder flag.
// ----------------------------------------------------------------------------
module pfs_rem_unit #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [W-1:0]          dividend,
    input  logic [W-1:0]          divisor,
    output pfs_pkg::pfs_rem_stat_t stat
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [W-1:0]  rem_reg,  rem_next;
    logic [W-1:0]  shf_reg,  shf_next;
    logic [W-1:0]  dvs_reg,  dvs_next;
    logic [W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, shf_reg[W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            shf_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            shf_next = {shf_reg[W-2:0], 1'b0};
            cnt_next = CW'(cnt_reg - 1'b1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

@@ hdl/prime_filter_and_sum_unit.sv @@
// ----------------------------------------------------------------------------
// prime_filter_and_sum_unit
// Trial-division primality test of each word with a saturating per-set sum
// of the primes; one result word per input word.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_stall  | value, last_item
//   out     | out_valid / out_stall| value_out, is_prime, prime_sum,
//           |                      | sum_overflow, last_out
//
// Each divisor is tried in turn in the bit-serial remainder unit (up to 46339
// divisors at VALUE_WIDTH=32); words below 2 skip the trial division.
// in_stall is high from acceptance until the result is in the output register.
// The output register holds a result under out_stall; the next word is taken
// meanwhile. Reset is asynchronous, active low, and clears sum and flag.
// ----------------------------------------------------------------------------
module prime_filter_and_sum_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    input  logic               last_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value_out,
    output logic               is_prime,
    output logic [30:0]        prime_sum,
    output logic               sum_overflow,
    output logic               last_out
);

    localparam int VW = VALUE_WIDTH;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [VW-1:0] D_INIT  = VW'(pfs_pkg::FIRST_DIVISOR);
    localparam logic [VW:0]   SQ_INIT =
        (VW+1)'(pfs_pkg::FIRST_DIVISOR * pfs_pkg::FIRST_DIVISOR);

    logic [1:0]      state_reg, state_next;
    logic [VW-1:0]   raw_reg,   raw_next;
    logic            last_reg,  last_next;
    logic [VW-1:0]   d_reg,     d_next;
    logic [VW:0]     sq_reg,    sq_next;
    logic            prime_reg, prime_next;
    logic [30:0]     sum_reg,   sum_next;
    logic            ovf_reg,   ovf_next;
    logic            ov_reg,    ov_next;
    logic [31:0]     vo_reg,    vo_next;
    logic            po_reg,    po_next;
    logic [30:0]     so_reg,    so_next;
    logic            fo_reg,    fo_next;
    logic            lo_reg,    lo_next;

    logic            rem_start;
    pfs_pkg::pfs_rem_stat_t rem_stat;
    logic [VW-1:0]   raw_in;
    logic [31:0]     total;
    logic [30:0]     sum_upd;
    logic            ovf_upd;

    pfs_rem_unit #(
        .W (VW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (raw_reg),
        .divisor  (d_reg),
        .stat     (rem_stat)
    );

    assign raw_in = value[VW-1:0];
    assign total  = {1'b0, sum_reg} + 32'(raw_reg);

    always_comb
    begin
        sum_upd = sum_reg;
        ovf_upd = ovf_reg;
        if (prime_reg)
        begin
            if (total > 32'(pfs_pkg::SUM_MAX))
            begin
                sum_upd = pfs_pkg::SUM_MAX;
                ovf_upd = 1'b1;
            end
            else
            begin
                sum_upd = total[30:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        raw_next   = raw_reg;
        last_next  = last_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        prime_next = prime_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        ov_next    = ov_reg;
        vo_next    = vo_reg;
        po_next    = po_reg;
        so_next    = so_reg;
        fo_next    = fo_reg;
        lo_next    = lo_reg;
        rem_start  = 1'b0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next   = raw_in;
                    last_next  = last_item;
                    d_next     = D_INIT;
                    sq_next    = SQ_INIT;
                    prime_next = 1'b0;
                    if (raw_in[VW-1] || (raw_in < D_INIT))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg <= {1'b0, raw_reg})
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.rem_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        d_next     = VW'(d_reg + 1'b1);
                        sq_next    = (VW+1)'(sq_reg + {d_reg, 1'b1});
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    vo_next    = 32'($signed(raw_reg));
                    po_next    = prime_reg;
                    so_next    = sum_upd;
                    fo_next    = ovf_upd;
                    lo_next    = last_reg;
                    sum_next   = last_reg ? '0 : sum_upd;
                    ovf_next   = last_reg ? 1'b0 : ovf_upd;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg   <= raw_next;
        last_reg  <= last_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
        vo_reg    <= vo_next;
        po_reg    <= po_next;
        so_reg    <= so_next;
        fo_reg    <= fo_next;
        lo_reg    <= lo_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = ov_reg;
    assign value_out    = $signed(vo_reg);
    assign is_prime     = po_reg;
    assign prime_sum    = so_reg;
    assign sum_overflow = fo_reg;
    assign last_out     = lo_reg;

endmodule
